>>> sv/ukvt_pkg.sv
// shared widths, operation codes and status codes of the key-value table
package ukvt_pkg;

	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;
	localparam int KIND_W   = 3;
	localparam int COUNT_W  = 9;
	localparam int STATUS_W = 2;

	// default number of table entries
	localparam int DEPTH_DEFAULT = 256;

	// packed item widths on the stream ports
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 48;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOOKUP = 3'd0,
		KIND_ACCESS = 3'd1,
		KIND_WRITE  = 3'd2,
		KIND_ERASE  = 3'd3,
		KIND_CLEAR  = 3'd4
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

endpackage

>>> sv/unsorted_key_value_table.sv
// key-value table held as a packed unordered array with a linear search sequencer
//
// Each item on the input stream is one operation on a table of up to DEPTH key-value
// entries held packed in two memories (keys and values), each with one read and one
// write port and registered reads.
// A sequencer walks the occupied entries from index 0 upward, reading each entry from
// memory and then comparing its key; a miss examines every occupied entry and a hit
// stops at the matching index. An erase that hits at index k then moves every later
// entry down by one slot, reading each moved entry and then writing it back. The input
// is not ready while an item is in work; the result sits in an output register, so the
// next item is accepted as soon as the sequencer is idle even while that result still
// waits to be taken. No clearing pass is needed after reset: only entries below the fill
// count are ever read.
module unsorted_key_value_table #(
	parameter int DEPTH = ukvt_pkg::DEPTH_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// key [31:0], value [63:32]
	input  logic [ukvt_pkg::IN_DATA_W-1:0]  s_tdata,
	// kind [2:0]
	input  logic [ukvt_pkg::KIND_W-1:0]     s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// read_value [31:0], found [32], entry_count [41:33], status [43:42], zero [47:44]
	output logic [ukvt_pkg::OUT_DATA_W-1:0] m_tdata
);

	import ukvt_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_RESOLVE,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_DONE
	} state_t;

	state_t            state_q;
	kind_t             kind_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;
	logic [AW-1:0]     idx_q;
	logic [CW-1:0]     count_q;
	logic              found_q;
	logic [VAL_W-1:0]  res_val_q;
	status_t           res_status_q;
	logic              m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	// table storage and registered read data
	logic [KEY_W-1:0]  key_mem [DEPTH];
	logic [VAL_W-1:0]  val_mem [DEPTH];
	logic [KEY_W-1:0]  rd_key_q;
	logic [VAL_W-1:0]  rd_val_q;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [KEY_W-1:0]  mem_wkey;
	logic [VAL_W-1:0]  mem_wval;
	logic [AW-1:0]     mem_raddr;

	logic [CW-1:0]     idx_next;
	logic              table_full;
	logic              shift_more;
	logic              out_free;

	assign s_tready   = (state_q == ST_IDLE);
	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign out_free   = !m_tvalid_q || m_tready;
	assign idx_next   = CW'(idx_q) + CW'(1);
	assign table_full = (count_q == CW'(DEPTH));
	// another entry to move after the one at idx_q + 1
	assign shift_more = ((CW + 1)'(idx_q) + (CW + 1)'(2)) < (CW + 1)'(count_q);

	// read address: the entry under test, or the entry above it while moving down
	always_comb begin
		if (state_q == ST_SHIFT_RD || state_q == ST_SHIFT_WR) begin
			mem_raddr = AW'(idx_next);
		end else begin
			mem_raddr = idx_q;
		end
	end

	// memory write: append, value update, or move down one slot
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wkey  = key_q;
		mem_wval  = val_q;
		if (state_q == ST_RESOLVE && !found_q && !table_full &&
				(kind_q == KIND_ACCESS || kind_q == KIND_WRITE)) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(count_q);
			mem_wval  = (kind_q == KIND_ACCESS) ? '0 : val_q;
		end else if (state_q == ST_RESOLVE && found_q && kind_q == KIND_WRITE) begin
			mem_we = 1'b1;
		end else if (state_q == ST_SHIFT_WR) begin
			mem_we   = 1'b1;
			mem_wkey = rd_key_q;
			mem_wval = rd_val_q;
		end
	end

	// key and value memories
	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[mem_waddr] <= mem_wkey;
			val_mem[mem_waddr] <= mem_wval;
		end
		rd_key_q <= key_mem[mem_raddr];
		rd_val_q <= val_mem[mem_raddr];
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			kind_q       <= KIND_LOOKUP;
			key_q        <= '0;
			val_q        <= '0;
			idx_q        <= '0;
			count_q      <= '0;
			found_q      <= 1'b0;
			res_val_q    <= '0;
			res_status_q <= STATUS_OK;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
		end else begin
			// result taken; the done state reloads it itself
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						kind_q       <= kind_t'(s_tuser);
						key_q        <= s_tdata[KEY_W-1:0];
						val_q        <= s_tdata[KEY_W +: VAL_W];
						idx_q        <= '0;
						found_q      <= 1'b0;
						res_val_q    <= '0;
						res_status_q <= STATUS_OK;
						if (s_tuser > KIND_W'(KIND_CLEAR)) begin
							state_q <= ST_DONE;
						end else if (count_q == '0) begin
							state_q <= ST_RESOLVE;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (rd_key_q == key_q) begin
						found_q <= 1'b1;
						state_q <= ST_RESOLVE;
					end else if (idx_next == count_q) begin
						state_q <= ST_RESOLVE;
					end else begin
						idx_q   <= AW'(idx_next);
						state_q <= ST_READ;
					end
				end
				ST_RESOLVE: begin
					state_q <= ST_DONE;
					case (kind_q)
						KIND_LOOKUP: begin
							if (found_q) begin
								res_val_q <= rd_val_q;
							end
						end
						KIND_ACCESS: begin
							if (found_q) begin
								res_val_q <= rd_val_q;
							end else if (table_full) begin
								res_status_q <= STATUS_FULL;
							end else begin
								count_q <= count_q + CW'(1);
							end
						end
						KIND_WRITE: begin
							if (found_q) begin
								res_val_q <= val_q;
							end else if (table_full) begin
								res_status_q <= STATUS_FULL;
							end else begin
								res_val_q <= val_q;
								count_q   <= count_q + CW'(1);
							end
						end
						KIND_ERASE: begin
							if (count_q == '0) begin
								res_status_q <= STATUS_EMPTY;
							end else if (found_q) begin
								if (idx_next < count_q) begin
									state_q <= ST_SHIFT_RD;
								end else begin
									count_q <= count_q - CW'(1);
								end
							end
						end
						KIND_CLEAR: begin
							count_q <= '0;
						end
						default: begin
						end
					endcase
				end
				ST_SHIFT_RD: begin
					state_q <= ST_SHIFT_WR;
				end
				ST_SHIFT_WR: begin
					idx_q <= AW'(idx_next);
					if (shift_more) begin
						state_q <= ST_SHIFT_RD;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {{(OUT_DATA_W - VAL_W - 1 - COUNT_W - STATUS_W){1'b0}},
							res_status_q, COUNT_W'(count_q), found_q, res_val_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// fill count never passes the table size
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(DEPTH))
		else $error("entry count above table size");

	// the input is not ready right after an item is accepted
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready right after an accepted item");

	// writes land inside the packed region or right at its end
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CW'(mem_waddr) <= count_q))
		else $error("memory write beyond the packed region");

	// the entry under test is always an occupied one
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> (CW'(idx_q) < count_q))
		else $error("search compared an unoccupied entry");

	// the fill count moves only when an operation resolves or a move finishes
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> ($past(state_q) == ST_RESOLVE || $past(state_q) == ST_SHIFT_WR))
		else $error("entry count changed outside resolve");
`endif

endmodule
